// File: src/eco_pkg.sv
// ============================================================================
// eco_pkg
// Shared constants, types and the cosine quarter-wave table for the easing
// curve evaluator.
// ============================================================================
`default_nettype none

package eco_pkg;

    localparam int FRACTION_BITS   = 15;
    localparam int COS_TABLE_DEPTH = 256;
    localparam int TAYLOR_TERMS    = 12;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned Q30    = 64'd1073741824;

    typedef enum logic [1:0] {
        CURVE_SINE = 2'd0,
        CURVE_BACK = 2'd1,
        CURVE_CIRC = 2'd2,
        CURVE_NONE = 2'd3
    } t_curve;

    typedef logic [30:0] t_cos_rom [0:COS_TABLE_DEPTH];

    typedef struct packed {
        logic [30:0] x;
        logic [31:0] r;
    } t_sq;

    // (2n-1)*(2n) for the Taylor terms
    localparam longint unsigned TAYLOR_DIV [1:TAYLOR_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
          64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

    function automatic t_cos_rom build_cos_rom();
        t_cos_rom        rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x    = (PI_Q30 * longint'(k)) / (2 * COS_TABLE_DEPTH);
            x2   = (x * x + 64'd536870912) >> 30;
            term = Q30;
            sum  = longint'(Q30);
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                term = ((term * x2 + 64'd536870912) >> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > longint'(Q30)) begin
                sum = longint'(Q30);
            end
            rom[k] = sum[30:0];
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_cos_rom();

    // one step of the bitwise floor square root, j = 0 is the top digit
    function automatic t_sq sq_step(input t_sq s, input int j);
        t_sq         o;
        logic [31:0] b;
        logic [32:0] sum;
        b   = 32'd1 << (30 - 2 * j);
        sum = {1'b0, s.r} + {1'b0, b};
        if ({2'b00, s.x} >= sum) begin
            o.x = s.x - sum[30:0];
            o.r = (s.r >> 1) + b;
        end else begin
            o.x = s.x;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// File: src/easing_curve_evaluator.sv
// ============================================================================
// easing_curve_evaluator
// Pipelined in-out easing: sine, back and circular curves in Q15.
// ============================================================================
//  channel  | direction | beat
//  s        | in        | i_s_tdata[15:0] progress
//  m        | out       | o_m_tdata[16:0] eased_value
//  cfg      | in        | i_cfg_data[1:0] curve_select
//
//  One beat per cycle sustained while i_m_tready is high; the circular
//  curve runs through eight two-digit square root stages.
//  Reset clears the valid bits and curve_select; payload is not reset.
//  Each stage advances when it is empty or the next one advances, so
//  bubbles collapse under an output stall.
`default_nettype none

module easing_curve_evaluator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [15:0] progress
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // [16:0] eased_value
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_data
);

    localparam int NSTG  = 11;
    localparam int TBL2  = 2 * eco_pkg::COS_TABLE_DEPTH;

    logic [1:0]      r_curve;
    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   s_en;

    logic [1:0]      r_sel [0:9];
    logic            r_low [1:9];

    // stage 0
    logic [15:0] r0_t;
    // stage 1
    logic signed [31:0] r1_c0, r1_c1;
    logic [14:0]        r1_frac;
    logic [30:0]        r1_wsq;
    logic signed [35:0] r1_lin;
    logic [30:0]        r1_rad;
    // stage 2
    logic signed [31:0] r2_c0;
    logic signed [47:0] r2_prod;
    logic [15:0]        r2_v2;
    logic signed [22:0] r2_inner;
    // stage 3
    logic signed [32:0] r3_c;
    logic signed [39:0] r3_p;
    // result delay and square root
    logic signed [16:0] r_y [4:9];
    eco_pkg::t_sq       r_sq [2:9];
    eco_pkg::t_sq       n_sq [2:9];
    logic signed [16:0] r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve <= eco_pkg::CURVE_SINE;
        end else if (i_cfg_valid) begin
            r_curve <= i_cfg_data;
        end
    end

    always_comb begin
        s_en[NSTG] = i_m_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            s_en[k] = !r_v[k] || s_en[k+1];
        end
    end

    assign o_s_tready = s_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (s_en[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (s_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en[0]) begin
            r_sel[0] <= r_curve;
        end
        for (int k = 1; k <= 9; k++) begin
            if (s_en[k]) begin
                r_sel[k] <= r_sel[k-1];
            end
        end
    end

    // ---- stage 0: saturate t
    always_ff @(posedge i_clk) begin
        if (s_en[0]) begin
            r0_t <= (i_s_tdata > 16'd32768) ? 16'd32768 : i_s_tdata;
        end
    end

    // ---- stage 1: table reads, squares, linear term
    function automatic logic signed [31:0] cos_at(input logic [9:0] i);
        logic [9:0] m;
        m = 10'(TBL2) - i;
        if (i <= 10'(eco_pkg::COS_TABLE_DEPTH)) begin
            return $signed({1'b0, eco_pkg::COS_ROM[i[8:0]]});
        end
        return -$signed({1'b0, eco_pkg::COS_ROM[m[8:0]]});
    endfunction

    logic               s1_low;
    logic [9:0]         s1_idx;
    logic [16:0]        s1_t2;
    logic signed [17:0] s1_wb;
    logic [16:0]        s1_wc;
    logic signed [35:0] s1_wsq;
    logic signed [35:0] s1_lin;
    logic [33:0]        s1_wcsq;
    logic [33:0]        s1_rad;
    logic signed [31:0] s1_c0;

    always_comb begin
        s1_low  = r0_t < 16'd16384;
        s1_idx  = r0_t[15:6];
        s1_t2   = {r0_t, 1'b0};
        s1_wb   = s1_low ? $signed({1'b0, s1_t2})
                         : $signed({1'b0, s1_t2}) - 18'sd65536;
        s1_wc   = s1_low ? s1_t2 : 17'd65536 - s1_t2;
        s1_wsq  = s1_wb * s1_wb;
        s1_lin  = s1_wb * 18'sd117798;
        s1_wcsq = s1_wc * s1_wc;
        s1_rad  = 34'd1073741824 - s1_wcsq;
        s1_c0   = cos_at(s1_idx);
    end

    always_ff @(posedge i_clk) begin
        if (s_en[1]) begin
            r_low[1] <= s1_low;
            r1_c0    <= s1_c0;
            r1_c1    <= (s1_idx < 10'(TBL2)) ? cos_at(s1_idx + 10'd1) : s1_c0;
            r1_frac  <= {r0_t[5:0], 9'd0};
            r1_wsq   <= s1_wsq[30:0];
            r1_lin   <= s1_lin;
            r1_rad   <= s1_rad[30:0];
        end
        for (int k = 2; k <= 9; k++) begin
            if (s_en[k]) begin
                r_low[k] <= r_low[k-1];
            end
        end
    end

    // ---- stage 2: interpolation product, back curve square and inner term
    logic signed [31:0] s2_diff;
    logic [31:0]        s2_v2;
    logic signed [37:0] s2_k;
    logic signed [37:0] s2_sum;

    always_comb begin
        s2_diff = r1_c1 - r1_c0;
        s2_v2   = {1'b0, r1_wsq} + 32'd16384;
        s2_k    = r_low[1] ? -38'sd2786263040 : 38'sd2786263040;
        s2_sum  = r1_lin + s2_k + 38'sd16384;
    end

    always_ff @(posedge i_clk) begin
        if (s_en[2]) begin
            r2_c0    <= r1_c0;
            r2_prod  <= s2_diff * $signed({1'b0, r1_frac});
            r2_v2    <= s2_v2[30:15];
            r2_inner <= s2_sum[37:15];
        end
    end

    // ---- stage 3: cosine value, back product
    logic signed [47:0] s3_pr;

    always_comb begin
        s3_pr = r2_prod + 48'sd16384;
    end

    always_ff @(posedge i_clk) begin
        if (s_en[3]) begin
            r3_c <= $signed({r2_c0[31], r2_c0}) + $signed(s3_pr[47:15]);
            r3_p <= $signed({1'b0, r2_v2}) * r2_inner;
        end
    end

    // ---- stage 4: sine and back results
    logic signed [33:0] s4_d;
    logic [33:0]        s4_ds;
    logic signed [40:0] s4_b;
    logic signed [24:0] s4_yb;
    logic signed [16:0] s4_y;

    always_comb begin
        s4_d  = 34'sd1073741824 - $signed({r3_c[32], r3_c});
        s4_ds = ((s4_d < 0) ? 34'd0 : s4_d) + 34'd32768;
        s4_b  = $signed({r3_p[39], r3_p}) + 41'sd32768
              + (r_low[3] ? 41'sd0 : 41'sd2147483648);
        s4_yb = s4_b[40:16];
        case (eco_pkg::t_curve'(r_sel[3]))
            eco_pkg::CURVE_SINE: s4_y = $signed(s4_ds[32:16]);
            eco_pkg::CURVE_BACK: begin
                if (s4_yb < -25'sd65536) begin
                    s4_y = -17'sd65536;
                end else if (s4_yb > 25'sd65535) begin
                    s4_y = 17'sd65535;
                end else begin
                    s4_y = s4_yb[16:0];
                end
            end
            default: s4_y = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_en[4]) begin
            r_y[4] <= s4_y;
        end
        for (int k = 5; k <= 9; k++) begin
            if (s_en[k]) begin
                r_y[k] <= r_y[k-1];
            end
        end
    end

    // ---- stages 2..9: floor square root, two digits per stage
    always_comb begin
        for (int k = 2; k <= 9; k++) begin
            n_sq[k] = eco_pkg::sq_step(
                eco_pkg::sq_step((k == 2) ? eco_pkg::t_sq'({r1_rad, 32'd0})
                                          : r_sq[(k == 2) ? 2 : k - 1],
                                 2 * (k - 2)),
                2 * (k - 2) + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 2; k <= 9; k++) begin
            if (s_en[k]) begin
                r_sq[k] <= n_sq[k];
            end
        end
    end

    // ---- stage 10: circular result and output register
    logic [16:0] s10_circ;

    always_comb begin
        s10_circ = r_low[9] ? 17'd32769 - {1'b0, r_sq[9].r[15:0]}
                            : 17'd32769 + {1'b0, r_sq[9].r[15:0]};
    end

    always_ff @(posedge i_clk) begin
        if (s_en[10]) begin
            r_out <= (eco_pkg::t_curve'(r_sel[9]) == eco_pkg::CURVE_CIRC)
                   ? $signed({1'b0, s10_circ[16:1]}) : r_y[9];
        end
    end

    assign o_m_tvalid = r_v[NSTG-1];
    assign o_m_tdata  = {7'd0, r_out};

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled with a bubble in the pipeline");
    a_unused_curve_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && r_sel[4] == eco_pkg::CURVE_NONE) |-> (r_y[4] == 17'sd0))
        else $error("unused curve gave a nonzero result");
`endif

endmodule

`default_nettype wire
